// ===== rtl/plti_pkg.sv =====
`default_nettype none
package plti_pkg;

  // Field widths of the item and result beats
  localparam int DATA_W = 32;
  localparam int MODE_W = 2;
  localparam int STAT_W = 3;

  // Width of the shared add/subtract unit: covers v0 +/- q for q up to 2^34
  localparam int ALU_W = 36;

  // A quotient above 2^SAT_Q_BIT saturates without forming the sum
  localparam int SAT_Q_BIT = 34;

  // Iteration counts of the shift-add multiply and the restoring divide
  localparam int MUL_STEPS = DATA_W;
  localparam int DIV_STEPS = 2 * DATA_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Result range of the signed output
  localparam logic signed [ALU_W-1:0] SUM_MAX =
    $signed((ALU_W'(1) << (DATA_W - 1)) - ALU_W'(1));
  localparam logic signed [ALU_W-1:0] SUM_MIN =
    -$signed(ALU_W'(1) << (DATA_W - 1));

  // Item modes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_DEGEN = 3'd2,
    ST_FULL  = 3'd3,
    ST_SAT   = 3'd4
  } status_t;

  // One request to the shared add/subtract unit
  typedef struct packed {
    logic signed [ALU_W-1:0] a;
    logic signed [ALU_W-1:0] b;
    logic                    sub;
  } alu_req_t;

endpackage
`default_nettype wire

// ===== rtl/plti_in_if.sv =====
`default_nettype none
interface plti_in_if;
  import plti_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] point_position;
  logic signed [DATA_W-1:0] point_value;

  modport source (output valid, mode, point_position, point_value, input ready);
  modport sink   (input valid, mode, point_position, point_value, output ready);

endinterface
`default_nettype wire

// ===== rtl/plti_out_if.sv =====
`default_nettype none
interface plti_out_if;
  import plti_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  status_t                  status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);

endinterface
`default_nettype wire

// ===== rtl/plti_ram.sv =====
`default_nettype none
module plti_ram #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/plti_alu.sv =====
`default_nettype none
module plti_alu (
  input  plti_pkg::alu_req_t                   req,
  output logic signed [plti_pkg::ALU_W-1:0]    y
);
  import plti_pkg::*;

  // Single shared adder/subtractor
  assign y = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule
`default_nettype wire

// ===== rtl/piecewise_linear_table_interp_unit.sv =====
`default_nettype none
// Piecewise-linear interpolation over a breakpoint table of up to MAX_POINTS
// signed Q(32-FRAC_BITS).FRAC_BITS points held in one single-port-read RAM.
// Each input beat gives one result beat. A query with at least two points
// binary-searches the stored positions (at most ceil(log2(MAX_POINTS))
// steps), loads the two segment ends, forms span, dx and dv and their
// magnitudes, then runs a 32-step shift-add multiply and a 64-step restoring
// divide on one shared 36-bit adder, and a final add with saturation. A
// degenerate span ends the query right after the span is formed. The input is
// ready only while the sequencer is idle; a finished result waits in the
// output register, so the next beat is taken while it is still pending. The
// search assumes positions stored in ascending order; queries past either end
// extrapolate along the end segment. Stored entries have no reset.
module piecewise_linear_table_interp_unit #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  plti_in_if.sink     in_ch,
  plti_out_if.source  out_ch
);
  import plti_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
  localparam logic [CW-1:0] CNT_TWO = CW'(2);
  // Largest span below 1e-6 in real terms
  localparam logic signed [ALU_W-1:0] DEGEN_MAX =
    ALU_W'(((1 << FRAC_BITS) - 1) / 1000000);

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_SRCH_RD  = 15'h0002,
    S_SRCH_CMP = 15'h0004,
    S_LD0      = 15'h0008,
    S_LD1      = 15'h0010,
    S_LD2      = 15'h0020,
    S_SPAN     = 15'h0040,
    S_DX       = 15'h0080,
    S_DXM      = 15'h0100,
    S_DV       = 15'h0200,
    S_DVM      = 15'h0400,
    S_MUL      = 15'h0800,
    S_DIV      = 15'h1000,
    S_SUM      = 15'h2000,
    S_FINISH   = 15'h4000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [AW-1:0]            left_r, left_nxt;
  logic [AW-1:0]            right_r, right_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] p0_r, p0_nxt, v0_r, v0_nxt;
  logic signed [DATA_W-1:0] p1_r, p1_nxt, v1_r, v1_nxt;
  logic [DATA_W-1:0]        span_r, span_nxt;
  logic signed [DATA_W:0]   dx_r, dx_nxt, dv_r, dv_nxt;
  logic [DATA_W-1:0]        hi_r, hi_nxt, lo_r, lo_nxt;
  logic [DATA_W-1:0]        mcand_r, mcand_nxt;
  logic [DATA_W-1:0]        rem_r, rem_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic signed [DATA_W-1:0] res_r, res_nxt;
  status_t                  st_r, st_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_res_r, out_res_nxt;
  status_t                  out_st_r, out_st_nxt;

  logic                     in_fire;
  logic [CW-1:0]            cnt_m1;
  logic [AW-1:0]            srch_l, srch_r;
  logic [AW:0]              mid_sum;
  logic [2*DATA_W-1:0]      quot;
  logic                     q_big;
  logic                     neg;
  logic                     ram_we;
  logic [AW-1:0]            ram_raddr;
  logic [2*DATA_W-1:0]      ram_rdata;
  logic signed [DATA_W-1:0] rd_pos, rd_val;
  alu_req_t                 alu_req;
  logic signed [ALU_W-1:0]  alu_y;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.status       = out_st_r;

  assign cnt_m1 = cnt_r - CW'(1);
  assign rd_pos = ram_rdata[2*DATA_W-1:DATA_W];
  assign rd_val = ram_rdata[DATA_W-1:0];
  assign quot   = {hi_r, lo_r};
  assign neg    = dx_r[DATA_W] ^ dv_r[DATA_W];
  assign q_big  = (|quot[2*DATA_W-1:SAT_Q_BIT+1]) ||
                  (quot[SAT_Q_BIT] && (|quot[SAT_Q_BIT-1:0]));

  // Narrow the search window on the compare result
  assign srch_l  = alu_y[ALU_W-1] ? idx_r : left_r;
  assign srch_r  = alu_y[ALU_W-1] ? right_r : idx_r;
  assign mid_sum = {1'b0, srch_l} + {1'b0, srch_r};

  // Breakpoint store: {position, value}
  assign ram_we    = in_fire && (in_ch.mode == MODE_APPEND) && (cnt_r != CNT_MAX);
  assign ram_raddr = (state_r == S_LD1) ? AW'(idx_r + AW'(1)) : idx_r;

  plti_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({in_ch.point_position, in_ch.point_value}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Steer the shared adder for the current step
  always_comb begin
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    unique case (state_r)
      S_SRCH_CMP: begin
        alu_req.a   = ALU_W'(rd_pos);
        alu_req.b   = ALU_W'(x_r);
        alu_req.sub = 1'b1;
      end
      S_SPAN: begin
        alu_req.a   = ALU_W'(p1_r);
        alu_req.b   = ALU_W'(p0_r);
        alu_req.sub = 1'b1;
      end
      S_DX: begin
        alu_req.a   = ALU_W'(x_r);
        alu_req.b   = ALU_W'(p0_r);
        alu_req.sub = 1'b1;
      end
      S_DXM: begin
        alu_req.b   = ALU_W'(dx_r);
        alu_req.sub = 1'b1;
      end
      S_DV: begin
        alu_req.a   = ALU_W'(v1_r);
        alu_req.b   = ALU_W'(v0_r);
        alu_req.sub = 1'b1;
      end
      S_DVM: begin
        alu_req.b   = ALU_W'(dv_r);
        alu_req.sub = 1'b1;
      end
      S_MUL: begin
        alu_req.a = ALU_W'(hi_r);
        alu_req.b = lo_r[0] ? ALU_W'(mcand_r) : '0;
      end
      S_DIV: begin
        alu_req.a   = ALU_W'({rem_r, hi_r[DATA_W-1]});
        alu_req.b   = ALU_W'(span_r);
        alu_req.sub = 1'b1;
      end
      S_SUM: begin
        alu_req.a   = ALU_W'(v0_r);
        alu_req.b   = ALU_W'(quot[SAT_Q_BIT:0]);
        alu_req.sub = neg;
      end
      S_IDLE, S_SRCH_RD, S_LD0, S_LD1, S_LD2, S_FINISH: begin
        alu_req.sub = 1'b0;
      end
      default: begin
        alu_req.sub = 1'b0;
      end
    endcase
  end

  plti_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    idx_nxt       = idx_r;
    x_nxt         = x_r;
    p0_nxt        = p0_r;
    v0_nxt        = v0_r;
    p1_nxt        = p1_r;
    v1_nxt        = v1_r;
    span_nxt      = span_r;
    dx_nxt        = dx_r;
    dv_nxt        = dv_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    mcand_nxt     = mcand_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    out_res_nxt   = out_res_r;
    out_st_nxt    = out_st_r;
    out_valid_nxt = out_valid_r;

    // Drop the output beat once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt   = '0;
          st_nxt    = ST_OK;
          state_nxt = S_FINISH;
          x_nxt     = in_ch.point_position;
          priority if (in_ch.mode == MODE_CLEAR) begin
            cnt_nxt = '0;
          end else if (in_ch.mode == MODE_APPEND) begin
            if (cnt_r == CNT_MAX) begin
              st_nxt = ST_FULL;
            end else begin
              cnt_nxt = cnt_r + CW'(1);
            end
          end else if (in_ch.mode == MODE_QUERY) begin
            if (cnt_r < CNT_TWO) begin
              st_nxt = ST_FEW;
            end else begin
              left_nxt  = '0;
              right_nxt = cnt_m1[AW-1:0];
              idx_nxt   = cnt_m1[AW-1:0] >> 1;
              state_nxt = ((cnt_m1[AW-1:0] >> 1) == '0) ? S_LD0 : S_SRCH_RD;
            end
          end else begin
            st_nxt = ST_OK;
          end
        end
      end
      S_SRCH_RD: begin
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        left_nxt  = srch_l;
        right_nxt = srch_r;
        idx_nxt   = mid_sum[AW:1];
        state_nxt = (mid_sum[AW:1] == srch_l) ? S_LD0 : S_SRCH_RD;
      end
      S_LD0: begin
        state_nxt = S_LD1;
      end
      S_LD1: begin
        p0_nxt    = rd_pos;
        v0_nxt    = rd_val;
        state_nxt = S_LD2;
      end
      S_LD2: begin
        p1_nxt    = rd_pos;
        v1_nxt    = rd_val;
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        span_nxt = alu_y[DATA_W-1:0];
        if (alu_y <= DEGEN_MAX) begin
          res_nxt   = '0;
          st_nxt    = ST_DEGEN;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_DX;
        end
      end
      S_DX: begin
        dx_nxt    = alu_y[DATA_W:0];
        state_nxt = S_DXM;
      end
      S_DXM: begin
        lo_nxt    = dx_r[DATA_W] ? alu_y[DATA_W-1:0] : dx_r[DATA_W-1:0];
        state_nxt = S_DV;
      end
      S_DV: begin
        dv_nxt    = alu_y[DATA_W:0];
        state_nxt = S_DVM;
      end
      S_DVM: begin
        mcand_nxt = dv_r[DATA_W] ? alu_y[DATA_W-1:0] : dv_r[DATA_W-1:0];
        hi_nxt    = '0;
        step_nxt  = '0;
        state_nxt = S_MUL;
      end
      // Shift-add multiply: |dx| * |dv| into {hi, lo}
      S_MUL: begin
        hi_nxt   = alu_y[DATA_W:1];
        lo_nxt   = {alu_y[0], lo_r[DATA_W-1:1]};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(MUL_STEPS - 1)) begin
          step_nxt  = '0;
          rem_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      // Restoring divide by span: quotient shifts into {hi, lo}
      S_DIV: begin
        if (alu_y[ALU_W-1]) begin
          rem_nxt = {rem_r[DATA_W-2:0], hi_r[DATA_W-1]};
        end else begin
          rem_nxt = alu_y[DATA_W-1:0];
        end
        {hi_nxt, lo_nxt} = {quot[2*DATA_W-2:0], ~alu_y[ALU_W-1]};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_SUM;
        end
      end
      // Add the signed quotient to v0 and clamp to the output range
      S_SUM: begin
        state_nxt = S_FINISH;
        priority if (q_big) begin
          res_nxt = neg ? SUM_MIN[DATA_W-1:0] : SUM_MAX[DATA_W-1:0];
          st_nxt  = ST_SAT;
        end else if (alu_y > SUM_MAX) begin
          res_nxt = SUM_MAX[DATA_W-1:0];
          st_nxt  = ST_SAT;
        end else if (alu_y < SUM_MIN) begin
          res_nxt = SUM_MIN[DATA_W-1:0];
          st_nxt  = ST_SAT;
        end else begin
          res_nxt = alu_y[DATA_W-1:0];
          st_nxt  = ST_OK;
        end
      end
      // Hold the result until the output register is free
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_res_nxt   = res_r;
          out_st_nxt    = st_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    left_r    <= left_nxt;
    right_r   <= right_nxt;
    idx_r     <= idx_nxt;
    x_r       <= x_nxt;
    p0_r      <= p0_nxt;
    v0_r      <= v0_nxt;
    p1_r      <= p1_nxt;
    v1_r      <= v1_nxt;
    span_r    <= span_nxt;
    dx_r      <= dx_nxt;
    dv_r      <= dv_nxt;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    mcand_r   <= mcand_nxt;
    rem_r     <= rem_nxt;
    step_r    <= step_nxt;
    res_r     <= res_nxt;
    st_r      <= st_nxt;
    out_res_r <= out_res_nxt;
    out_st_r  <= out_st_nxt;
  end

  // The segment always has a next breakpoint
  a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD0) |-> (idx_r < right_r))
    else $error("segment index not below upper bound");

  // A clear beat empties the table
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.mode == MODE_CLEAR)) |=> (cnt_r == '0))
    else $error("table not empty after clear");

  // An append to a non-full table grows it by one
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.mode == MODE_APPEND) && (cnt_r != CNT_MAX))
      |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("append did not grow the table");

  // FEW, DEGEN and FULL results carry a zero value; non-query results are zero too but go unchecked
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && ((out_ch.status == ST_FEW) || (out_ch.status == ST_DEGEN) ||
                      (out_ch.status == ST_FULL)))
      |-> (out_ch.result_value == '0))
    else $error("error status with nonzero value");

endmodule
`default_nettype wire
